FILE: hdl/assert_macros.svh
// assertion helpers used by the checker of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on the rising clock edge outside reset
`define UVS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a signal holds in the cycle after a condition
`define UVS_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) else $error(msg);

`endif

FILE: hdl/uvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// widths, constants, types and the arctangent table of the uv sphere core
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int SUB_W            = 11;
	localparam int MAX_SUBDIVISIONS = 1024;
	localparam int SUB_RESET        = 32;
	localparam int FRAC_BITS        = 32;
	localparam int Q_W              = FRAC_BITS + 1;
	localparam int TEX_FRAC         = 16;
	localparam int PHI_FRAC         = FRAC_BITS - 1;
	localparam int CORDIC_STEPS     = 16;
	localparam int CW               = 34;
	localparam int ANG_W            = 32;
	localparam int MAG_W            = 31;
	localparam int IDX_W            = 21;
	localparam int TEX_W            = 17;
	localparam int POS_W            = 16;
	localparam int PROD_W           = 64;
	localparam int MUL_W            = 32;
	localparam int POS_SHIFT        = 45;
	localparam int POS_Y_SHIFT      = 15;
	localparam int DIV_STAGES       = FRAC_BITS + 1;
	localparam int CORDIC_LAT       = CORDIC_STEPS + 1;
	localparam int SIDE_LAT         = DIV_STAGES + 4 + CORDIC_LAT + 1;
	localparam int TEX_LAT          = SIDE_LAT - DIV_STAGES;
	localparam int FIFO_DEPTH       = 4;
	localparam int FIFO_AW          = $clog2(FIFO_DEPTH);
	localparam int CNT_W            = FIFO_AW + 1;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [MAG_W-1:0]     HALF_PI     = 31'd1686629713;
	localparam logic signed [PROD_W-1:0] POS_MAX = 64'sd32767;
	localparam logic signed [PROD_W-1:0] POS_MIN = -64'sd32768;

	typedef struct packed {
		logic [SUB_W-1:0] col;
		logic [SUB_W-1:0] row;
		logic [SUB_W-1:0] s;
		logic             valid;
		logic             has_quad;
		logic [IDX_W-1:0] top;
		logic [IDX_W-1:0] below;
	} entry_t;

	typedef struct packed {
		logic             valid;
		logic             has_quad;
		logic [IDX_W-1:0] top;
		logic [IDX_W-1:0] below;
	} side_t;

	// round-up decisions of the divider at the three fraction lengths
	typedef struct packed {
		logic tex;
		logic half;
		logic full;
	} rnd_t;

	function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
		unique case (idx)
			0:  return 34'sd843314856;
			1:  return 34'sd497837829;
			2:  return 34'sd263043836;
			3:  return 34'sd133525158;
			4:  return 34'sd67021686;
			5:  return 34'sd33543515;
			6:  return 34'sd16775850;
			7:  return 34'sd8388437;
			8:  return 34'sd4194282;
			9:  return 34'sd2097149;
			10: return 34'sd1048575;
			11: return 34'sd524287;
			12: return 34'sd262143;
			13: return 34'sd131071;
			14: return 34'sd65535;
			15: return 34'sd32767;
			16: return 34'sd16383;
			17: return 34'sd8191;
			18: return 34'sd4095;
			19: return 34'sd2047;
			20: return 34'sd1023;
			21: return 34'sd511;
			22: return 34'sd255;
			23: return 34'sd127;
			default: return '0;
		endcase
	endfunction

endpackage

FILE: hdl/uvs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_if
// valid/ready channels for grid points in and vertices out
// ----------------------------------------------------------------------------
interface uvs_grid_if;
	logic                     valid;
	logic                     ready;
	logic [uvs_pkg::SUB_W-1:0] grid_column;
	logic [uvs_pkg::SUB_W-1:0] grid_row;

	modport source(output valid, grid_column, grid_row, input ready);
	modport sink(input valid, grid_column, grid_row, output ready);
endinterface

interface uvs_vertex_if;
	logic                            valid;
	logic                            ready;
	logic                            point_valid;
	logic signed [uvs_pkg::POS_W-1:0] pos_x;
	logic signed [uvs_pkg::POS_W-1:0] pos_y;
	logic signed [uvs_pkg::POS_W-1:0] pos_z;
	logic [uvs_pkg::TEX_W-1:0]        tex_u;
	logic [uvs_pkg::TEX_W-1:0]        tex_v;
	logic                            has_quad;
	logic [uvs_pkg::IDX_W-1:0]        quad_top;
	logic [uvs_pkg::IDX_W-1:0]        quad_below;

	modport source(output valid, point_valid, pos_x, pos_y, pos_z, tex_u, tex_v,
		has_quad, quad_top, quad_below, input ready);
	modport sink(input valid, point_valid, pos_x, pos_y, pos_z, tex_u, tex_v,
		has_quad, quad_top, quad_below, output ready);
endinterface

FILE: hdl/uv_sphere_vertex_generator_core.sv
`timescale 1ns / 1ps
// throughput: one word per cycle unless the output stalls, set by the one-bit-per-stage
//   dividers and the one-rotation-per-stage cordic pair, all fully pipelined
// reset: arst_n clears queue, pipeline valid bits and output valid;
//   subdivisions returns to 32
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// uv sphere grid point to position, texture coordinate and quad base indices
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core (
	input  logic                      clk,
	input  logic                      arst_n,
	uvs_grid_if.sink                  grid,
	uvs_vertex_if.source              vertex,
	input  logic                      cfg_we,
	input  logic [uvs_pkg::SUB_W-1:0] cfg_wdata
);
	// subdivision count, clamped per word in the front end
	logic [uvs_pkg::SUB_W-1:0] subdivisions_q;

	// queue head between front and back
	uvs_pkg::entry_t head;
	logic            head_valid;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			subdivisions_q <= uvs_pkg::SUB_W'(uvs_pkg::SUB_RESET);
		else if (cfg_we)
			subdivisions_q <= cfg_wdata;
	end

	// front: accept, range check, quad indices, four-entry queue
	uvs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.grid(grid),
		.subdivisions(subdivisions_q),
		.pop(pop),
		.head(head),
		.head_valid(head_valid)
	);

	// back: dividers, angle fold, cordic pair, products, output register
	uvs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.vertex(vertex)
	);
endmodule

FILE: hdl/uvs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_divider
// pipelined restoring divider, one quotient bit per stage, with round-up flags
// ----------------------------------------------------------------------------
module uvs_divider (
	input  logic                       clk,
	input  logic                       en,
	input  logic [uvs_pkg::SUB_W-1:0]  num,
	input  logic [uvs_pkg::SUB_W-1:0]  den,
	output logic [uvs_pkg::Q_W-1:0]    quo,
	output uvs_pkg::rnd_t              rnd
);
	logic [uvs_pkg::SUB_W-1:0] r_s [0:uvs_pkg::FRAC_BITS];
	logic [uvs_pkg::SUB_W-1:0] d_s [0:uvs_pkg::FRAC_BITS];
	logic [uvs_pkg::SUB_W-1:0] h_s [0:uvs_pkg::FRAC_BITS];
	logic [uvs_pkg::Q_W-1:0]   q_s [0:uvs_pkg::FRAC_BITS];
	uvs_pkg::rnd_t             f_s [0:uvs_pkg::FRAC_BITS];

	logic [uvs_pkg::SUB_W-1:0] r_n [0:uvs_pkg::FRAC_BITS];
	logic [uvs_pkg::SUB_W-1:0] d_n [0:uvs_pkg::FRAC_BITS];
	logic [uvs_pkg::SUB_W-1:0] h_n [0:uvs_pkg::FRAC_BITS];
	logic [uvs_pkg::Q_W-1:0]   q_n [0:uvs_pkg::FRAC_BITS];
	uvs_pkg::rnd_t             f_n [0:uvs_pkg::FRAC_BITS];

	always_comb begin
		logic                      ib;
		logic                      b;
		logic [uvs_pkg::SUB_W:0]   t;
		logic [uvs_pkg::SUB_W:0]   hs;
		logic [uvs_pkg::SUB_W-1:0] rn;
		// integer bit
		ib     = (num >= den);
		hs     = {1'b0, den} + (uvs_pkg::SUB_W+1)'(1);
		r_n[0] = ib ? num - den : num;
		q_n[0] = {ib, uvs_pkg::FRAC_BITS'(0)};
		d_n[0] = den;
		h_n[0] = hs[uvs_pkg::SUB_W:1];
		f_n[0] = '0;
		for (int k = 1; k <= uvs_pkg::FRAC_BITS; k++) begin
			t      = {r_s[k-1], 1'b0};
			b      = (t >= {1'b0, d_s[k-1]});
			rn     = b ? uvs_pkg::SUB_W'(t - {1'b0, d_s[k-1]}) : t[uvs_pkg::SUB_W-1:0];
			r_n[k] = rn;
			q_n[k] = q_s[k-1] | (uvs_pkg::Q_W'(b) << (uvs_pkg::FRAC_BITS - k));
			d_n[k] = d_s[k-1];
			h_n[k] = h_s[k-1];
			f_n[k] = f_s[k-1];
			// remainder at least ceil(s/2) means round up
			if (k == uvs_pkg::TEX_FRAC)
				f_n[k].tex = (rn >= h_s[k-1]);
			if (k == uvs_pkg::PHI_FRAC)
				f_n[k].half = (rn >= h_s[k-1]);
			if (k == uvs_pkg::FRAC_BITS)
				f_n[k].full = (rn >= h_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s <= r_n;
			d_s <= d_n;
			h_s <= h_n;
			q_s <= q_n;
			f_s <= f_n;
		end
	end

	assign quo = q_s[uvs_pkg::FRAC_BITS];
	assign rnd = f_s[uvs_pkg::FRAC_BITS];
endmodule

FILE: hdl/uvs_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_cordic
// pipelined rotation-mode cordic, one micro-rotation per stage, q30 sin and cos
// ----------------------------------------------------------------------------
module uvs_cordic (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [uvs_pkg::CW-1:0] z,
	input  logic                          neg,
	output logic signed [uvs_pkg::CW-1:0] cos_o,
	output logic signed [uvs_pkg::CW-1:0] sin_o
);
	logic signed [uvs_pkg::CW-1:0] x_s [0:uvs_pkg::CORDIC_STEPS-1];
	logic signed [uvs_pkg::CW-1:0] y_s [0:uvs_pkg::CORDIC_STEPS-1];
	logic signed [uvs_pkg::CW-1:0] z_s [0:uvs_pkg::CORDIC_STEPS-1];
	logic                          n_s [0:uvs_pkg::CORDIC_STEPS-1];

	logic signed [uvs_pkg::CW-1:0] x_i [0:uvs_pkg::CORDIC_STEPS-1];
	logic signed [uvs_pkg::CW-1:0] y_i [0:uvs_pkg::CORDIC_STEPS-1];
	logic signed [uvs_pkg::CW-1:0] z_i [0:uvs_pkg::CORDIC_STEPS-1];
	logic                          n_i [0:uvs_pkg::CORDIC_STEPS-1];

	logic signed [uvs_pkg::CW-1:0] x_n [0:uvs_pkg::CORDIC_STEPS-1];
	logic signed [uvs_pkg::CW-1:0] y_n [0:uvs_pkg::CORDIC_STEPS-1];
	logic signed [uvs_pkg::CW-1:0] z_n [0:uvs_pkg::CORDIC_STEPS-1];

	logic signed [uvs_pkg::CW-1:0] cos_q;
	logic signed [uvs_pkg::CW-1:0] sin_q;

	always_comb begin
		x_i[0] = uvs_pkg::CORDIC_GAIN;
		y_i[0] = '0;
		z_i[0] = z;
		n_i[0] = neg;
		for (int i = 1; i < uvs_pkg::CORDIC_STEPS; i++) begin
			x_i[i] = x_s[i-1];
			y_i[i] = y_s[i-1];
			z_i[i] = z_s[i-1];
			n_i[i] = n_s[i-1];
		end
	end

	always_comb begin
		logic signed [uvs_pkg::CW-1:0] xs;
		logic signed [uvs_pkg::CW-1:0] ys;
		for (int i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin
			xs = x_i[i] >>> i;
			ys = y_i[i] >>> i;
			if (!z_i[i][uvs_pkg::CW-1]) begin
				x_n[i] = x_i[i] - ys;
				y_n[i] = y_i[i] + xs;
				z_n[i] = z_i[i] - uvs_pkg::atan_q30(i);
			end else begin
				x_n[i] = x_i[i] + ys;
				y_n[i] = y_i[i] - xs;
				z_n[i] = z_i[i] + uvs_pkg::atan_q30(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s   <= x_n;
			y_s   <= y_n;
			z_s   <= z_n;
			n_s   <= n_i;
			// half-turn fold negates both outputs
			cos_q <= n_s[uvs_pkg::CORDIC_STEPS-1] ? -x_s[uvs_pkg::CORDIC_STEPS-1]
				: x_s[uvs_pkg::CORDIC_STEPS-1];
			sin_q <= n_s[uvs_pkg::CORDIC_STEPS-1] ? -y_s[uvs_pkg::CORDIC_STEPS-1]
				: y_s[uvs_pkg::CORDIC_STEPS-1];
		end
	end

	assign cos_o = cos_q;
	assign sin_o = sin_q;
endmodule

FILE: hdl/uvs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_front
// accepts grid points, classifies them, computes quad indices, queues them
// ----------------------------------------------------------------------------
module uvs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	uvs_grid_if.sink                  grid,
	input  logic [uvs_pkg::SUB_W-1:0] subdivisions,
	input  logic                      pop,
	output uvs_pkg::entry_t           head,
	output logic                      head_valid
);
	uvs_pkg::entry_t             mem_q [0:uvs_pkg::FIFO_DEPTH-1];
	logic [uvs_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [uvs_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [uvs_pkg::CNT_W-1:0]   cnt_q;

	logic [uvs_pkg::SUB_W-1:0]   s_eff;
	logic [uvs_pkg::SUB_W:0]     span;
	logic [2*uvs_pkg::SUB_W:0]   row_base;
	logic [uvs_pkg::IDX_W-1:0]   top;
	uvs_pkg::entry_t             ent;
	logic                        push;

	always_comb begin
		if (subdivisions == '0)
			s_eff = uvs_pkg::SUB_W'(1);
		else if (subdivisions > uvs_pkg::SUB_W'(uvs_pkg::MAX_SUBDIVISIONS))
			s_eff = uvs_pkg::SUB_W'(uvs_pkg::MAX_SUBDIVISIONS);
		else
			s_eff = subdivisions;
		span     = {1'b0, s_eff} + (uvs_pkg::SUB_W+1)'(1);
		row_base = (2*uvs_pkg::SUB_W+1)'(grid.grid_row) * (2*uvs_pkg::SUB_W+1)'(span);
		top      = uvs_pkg::IDX_W'(row_base + (2*uvs_pkg::SUB_W+1)'(grid.grid_column));

		ent.col      = grid.grid_column;
		ent.row      = grid.grid_row;
		ent.s        = s_eff;
		ent.valid    = (grid.grid_column <= s_eff) && (grid.grid_row <= s_eff);
		ent.has_quad = (grid.grid_column < s_eff) && (grid.grid_row < s_eff);
		ent.top      = ent.has_quad ? top : '0;
		ent.below    = ent.has_quad ? top + uvs_pkg::IDX_W'(span) : '0;
	end

	assign grid.ready = (cnt_q != uvs_pkg::CNT_W'(uvs_pkg::FIFO_DEPTH));
	assign push       = grid.valid && grid.ready;
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + uvs_pkg::FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + uvs_pkg::FIFO_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + uvs_pkg::CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - uvs_pkg::CNT_W'(1);
		end
	end
endmodule

FILE: hdl/uvs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_back
// divides, folds, runs the cordic pair, forms position and the output word
// ----------------------------------------------------------------------------
module uvs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  uvs_pkg::entry_t head,
	input  logic            head_valid,
	output logic            pop,
	uvs_vertex_if.source    vertex
);
	typedef struct packed {
		logic [uvs_pkg::MAG_W-1:0] mag;
		logic                      neg_ang;
		logic                      neg_out;
	} fold_t;

	typedef struct packed {
		logic [uvs_pkg::TEX_W-1:0] u;
		logic [uvs_pkg::TEX_W-1:0] v;
	} tex_t;

	function automatic fold_t fold(input logic [uvs_pkg::ANG_W-1:0] ang);
		logic signed [uvs_pkg::ANG_W:0] a;
		logic signed [uvs_pkg::ANG_W:0] m;
		fold_t f;
		a = $signed({ang[uvs_pkg::ANG_W-1], ang});
		f.neg_out = 1'b0;
		if (a > (33'sd1 <<< 30)) begin
			a = a - (33'sd1 <<< 31);
			f.neg_out = 1'b1;
		end else if (a < -(33'sd1 <<< 30)) begin
			a = a + (33'sd1 <<< 31);
			f.neg_out = 1'b1;
		end
		f.neg_ang = a[uvs_pkg::ANG_W];
		m = f.neg_ang ? -a : a;
		f.mag = m[uvs_pkg::MAG_W-1:0];
		return f;
	endfunction

	function automatic logic signed [uvs_pkg::POS_W-1:0] sat_pos(
		input logic signed [uvs_pkg::PROD_W-1:0] v);
		if (v > uvs_pkg::POS_MAX)
			return uvs_pkg::POS_MAX[uvs_pkg::POS_W-1:0];
		else if (v < uvs_pkg::POS_MIN)
			return uvs_pkg::POS_MIN[uvs_pkg::POS_W-1:0];
		else
			return v[uvs_pkg::POS_W-1:0];
	endfunction

	logic adv;
	logic out_valid_q;

	logic          vld_q  [0:uvs_pkg::SIDE_LAT-1];
	uvs_pkg::side_t side_q [0:uvs_pkg::SIDE_LAT-1];
	tex_t          tex_s  [0:uvs_pkg::TEX_LAT-1];

	logic [uvs_pkg::Q_W-1:0] col_quo;
	logic [uvs_pkg::Q_W-1:0] row_quo;
	uvs_pkg::rnd_t           col_rnd;
	uvs_pkg::rnd_t           row_rnd;

	logic [uvs_pkg::ANG_W-1:0]   theta_s1;
	logic [uvs_pkg::ANG_W-1:0]   phi_s1;
	fold_t                       theta_s2;
	fold_t                       phi_s2;
	logic [2*uvs_pkg::MAG_W-1:0] t_prod_s3;
	logic [2*uvs_pkg::MAG_W-1:0] p_prod_s3;
	logic                        t_nang_s3, t_nout_s3, p_nang_s3, p_nout_s3;
	logic signed [uvs_pkg::CW-1:0] t_z_s4;
	logic signed [uvs_pkg::CW-1:0] p_z_s4;
	logic                        t_nout_s4, p_nout_s4;

	logic signed [uvs_pkg::CW-1:0] ct, st, cp, sp;
	logic signed [uvs_pkg::MUL_W-1:0] ct_m, st_m, sp_m;
	logic signed [uvs_pkg::PROD_W-1:0] px_s6, pz_s6;
	logic signed [uvs_pkg::CW-1:0]     py_s6;

	logic [2*uvs_pkg::MAG_W-1:0] t_rsum, p_rsum;
	logic [uvs_pkg::CW-1:0]      t_zmag, p_zmag;
	logic signed [uvs_pkg::PROD_W-1:0] rx, ry, rz;

	logic                          point_valid_q, has_quad_q;
	logic signed [uvs_pkg::POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [uvs_pkg::TEX_W-1:0]     tex_u_q, tex_v_q;
	logic [uvs_pkg::IDX_W-1:0]     quad_top_q, quad_below_q;

	// whole back end moves together; output register frees it when taken
	assign adv = !out_valid_q || vertex.ready;
	assign pop = adv && head_valid;

	uvs_divider u_col_div (
		.clk(clk), .en(adv), .num(head.col), .den(head.s), .quo(col_quo), .rnd(col_rnd)
	);
	uvs_divider u_row_div (
		.clk(clk), .en(adv), .num(head.row), .den(head.s), .quo(row_quo), .rnd(row_rnd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < uvs_pkg::SIDE_LAT; i++)
				vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= head_valid;
			for (int i = 1; i < uvs_pkg::SIDE_LAT; i++)
				vld_q[i] <= vld_q[i-1];
			out_valid_q <= vld_q[uvs_pkg::SIDE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= '{valid: head.valid, has_quad: head.has_quad,
				top: head.top, below: head.below};
			for (int i = 1; i < uvs_pkg::SIDE_LAT; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// angles and texture coordinates from the quotients
	always_ff @(posedge clk) begin
		if (adv) begin
			theta_s1 <= col_quo[uvs_pkg::ANG_W-1:0] + uvs_pkg::ANG_W'(col_rnd.full);
			phi_s1   <= row_quo[uvs_pkg::Q_W-1:1] + uvs_pkg::ANG_W'(row_rnd.half);
			tex_s[0] <= '{u: col_quo[uvs_pkg::Q_W-1:uvs_pkg::TEX_FRAC]
					+ uvs_pkg::TEX_W'(col_rnd.tex),
				v: row_quo[uvs_pkg::Q_W-1:uvs_pkg::TEX_FRAC]
					+ uvs_pkg::TEX_W'(row_rnd.tex)};
			for (int i = 1; i < uvs_pkg::TEX_LAT; i++)
				tex_s[i] <= tex_s[i-1];
		end
	end

	// fold to a quarter turn, then scale to radians
	always_ff @(posedge clk) begin
		if (adv) begin
			theta_s2  <= fold(theta_s1);
			phi_s2    <= fold(phi_s1);
			t_prod_s3 <= (2*uvs_pkg::MAG_W)'(theta_s2.mag) * (2*uvs_pkg::MAG_W)'(uvs_pkg::HALF_PI);
			p_prod_s3 <= (2*uvs_pkg::MAG_W)'(phi_s2.mag) * (2*uvs_pkg::MAG_W)'(uvs_pkg::HALF_PI);
			t_nang_s3 <= theta_s2.neg_ang;
			t_nout_s3 <= theta_s2.neg_out;
			p_nang_s3 <= phi_s2.neg_ang;
			p_nout_s3 <= phi_s2.neg_out;
		end
	end

	always_comb begin
		t_rsum = t_prod_s3 + ((2*uvs_pkg::MAG_W)'(1) << (uvs_pkg::MAG_W - 2));
		p_rsum = p_prod_s3 + ((2*uvs_pkg::MAG_W)'(1) << (uvs_pkg::MAG_W - 2));
		t_zmag = {2'b00, t_rsum[2*uvs_pkg::MAG_W-1:uvs_pkg::MAG_W-1]};
		p_zmag = {2'b00, p_rsum[2*uvs_pkg::MAG_W-1:uvs_pkg::MAG_W-1]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_z_s4    <= t_nang_s3 ? -$signed(t_zmag) : $signed(t_zmag);
			p_z_s4    <= p_nang_s3 ? -$signed(p_zmag) : $signed(p_zmag);
			t_nout_s4 <= t_nout_s3;
			p_nout_s4 <= p_nout_s3;
		end
	end

	uvs_cordic u_theta_cordic (
		.clk(clk), .en(adv), .z(t_z_s4), .neg(t_nout_s4), .cos_o(ct), .sin_o(st)
	);
	uvs_cordic u_phi_cordic (
		.clk(clk), .en(adv), .z(p_z_s4), .neg(p_nout_s4), .cos_o(cp), .sin_o(sp)
	);

	assign ct_m = ct[uvs_pkg::MUL_W-1:0];
	assign st_m = st[uvs_pkg::MUL_W-1:0];
	assign sp_m = sp[uvs_pkg::MUL_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s6 <= sp_m * ct_m;
			pz_s6 <= sp_m * st_m;
			py_s6 <= cp;
		end
	end

	always_comb begin
		rx = (px_s6 + (uvs_pkg::PROD_W'(1) << (uvs_pkg::POS_SHIFT - 1))) >>> uvs_pkg::POS_SHIFT;
		rz = (pz_s6 + (uvs_pkg::PROD_W'(1) << (uvs_pkg::POS_SHIFT - 1))) >>> uvs_pkg::POS_SHIFT;
		ry = (uvs_pkg::PROD_W'(py_s6) + (uvs_pkg::PROD_W'(1) << (uvs_pkg::POS_Y_SHIFT - 1)))
			>>> uvs_pkg::POS_Y_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_valid_q <= side_q[uvs_pkg::SIDE_LAT-1].valid;
			has_quad_q    <= side_q[uvs_pkg::SIDE_LAT-1].has_quad;
			quad_top_q    <= side_q[uvs_pkg::SIDE_LAT-1].top;
			quad_below_q  <= side_q[uvs_pkg::SIDE_LAT-1].below;
			if (side_q[uvs_pkg::SIDE_LAT-1].valid) begin
				pos_x_q <= sat_pos(rx);
				pos_y_q <= sat_pos(ry);
				pos_z_q <= sat_pos(rz);
				tex_u_q <= tex_s[uvs_pkg::TEX_LAT-1].u;
				tex_v_q <= tex_s[uvs_pkg::TEX_LAT-1].v;
			end else begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
				tex_u_q <= '0;
				tex_v_q <= '0;
			end
		end
	end

	assign vertex.valid       = out_valid_q;
	assign vertex.point_valid = point_valid_q;
	assign vertex.pos_x       = pos_x_q;
	assign vertex.pos_y       = pos_y_q;
	assign vertex.pos_z       = pos_z_q;
	assign vertex.tex_u       = tex_u_q;
	assign vertex.tex_v       = tex_v_q;
	assign vertex.has_quad    = has_quad_q;
	assign vertex.quad_top    = quad_top_q;
	assign vertex.quad_below  = quad_below_q;
endmodule

FILE: hdl/uvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_checker
// port-level checks of the vertex output of the uv sphere core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uvs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              point_valid,
	input logic signed [uvs_pkg::POS_W-1:0]  pos_x,
	input logic signed [uvs_pkg::POS_W-1:0]  pos_y,
	input logic signed [uvs_pkg::POS_W-1:0]  pos_z,
	input logic [uvs_pkg::TEX_W-1:0]         tex_u,
	input logic [uvs_pkg::TEX_W-1:0]         tex_v,
	input logic                              has_quad,
	input logic [uvs_pkg::IDX_W-1:0]         quad_top,
	input logic [uvs_pkg::IDX_W-1:0]         quad_below
);
	logic [2+3*uvs_pkg::POS_W+2*uvs_pkg::TEX_W+2*uvs_pkg::IDX_W-1:0] word;
	logic stalled;

	assign word    = {point_valid, pos_x, pos_y, pos_z, tex_u, tex_v,
		has_quad, quad_top, quad_below};
	assign stalled = out_valid && !out_ready;

	`UVS_HOLD(a_word_held, clk, arst_n, stalled, word, "vertex word changed while stalled")
	`UVS_ASSERT(a_outside_zero, clk, arst_n, out_valid && !point_valid |-> pos_x == '0 && pos_y == '0 && pos_z == '0 && tex_u == '0 && tex_v == '0 && !has_quad, "point outside grid has nonzero fields")
	`UVS_ASSERT(a_quad_order, clk, arst_n, out_valid && has_quad |-> point_valid && quad_below > quad_top, "quad on invalid point or indices out of order")
	`UVS_ASSERT(a_no_quad_zero, clk, arst_n, out_valid && !has_quad |-> quad_top == '0 && quad_below == '0, "quad indices set without a quad")
	`UVS_ASSERT(a_tex_range, clk, arst_n, out_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536, "texture coordinate above one")
endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(vertex.valid),
	.out_ready(vertex.ready),
	.point_valid(vertex.point_valid),
	.pos_x(vertex.pos_x),
	.pos_y(vertex.pos_y),
	.pos_z(vertex.pos_z),
	.tex_u(vertex.tex_u),
	.tex_v(vertex.tex_v),
	.has_quad(vertex.has_quad),
	.quad_top(vertex.quad_top),
	.quad_below(vertex.quad_below)
);
